// ----- src/ctm_pkg.sv -----
`timescale 1ns / 1ps

package ctm_pkg;

   localparam int TEMPLATE_COUNT = 42;
   localparam int ROM_ENTRIES    = 42;
   localparam int TPL_SCAN       = (TEMPLATE_COUNT < ROM_ENTRIES) ? TEMPLATE_COUNT : ROM_ENTRIES;

   localparam int PC_COUNT  = 12;
   localparam int PC_W      = 4;
   localparam int TPL_IDX_W = 6;
   localparam int SCORE_W   = 8;

   localparam logic [PC_W-1:0]      LAST_ROOT  = PC_W'(PC_COUNT - 1);
   localparam logic [TPL_IDX_W-1:0] LAST_TPL   = TPL_IDX_W'(TPL_SCAN - 1);
   localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -8'sd100;

   typedef struct packed {
      logic [PC_COUNT-1:0] mask;
      logic                maj;
      logic                dim;
   } tpl_entry_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctm_cmd_type;

   typedef struct packed {
      logic last_step;
   } ctm_sts_type;

   function automatic tpl_entry_type tpl_rom(input logic [TPL_IDX_W-1:0] idx);
      tpl_entry_type e;
      unique case (idx)
         6'd0:  e = '{12'b000010010001, 1'b1, 1'b0};
         6'd1:  e = '{12'b000010001001, 1'b0, 1'b0};
         6'd2:  e = '{12'b000001001001, 1'b0, 1'b1};
         6'd3:  e = '{12'b000100010001, 1'b1, 1'b0};
         6'd4:  e = '{12'b000010000101, 1'b1, 1'b0};
         6'd5:  e = '{12'b000010100001, 1'b1, 1'b0};
         6'd6:  e = '{12'b000010100101, 1'b1, 1'b0};
         6'd7:  e = '{12'b001010010001, 1'b1, 1'b0};
         6'd8:  e = '{12'b001010001001, 1'b0, 1'b0};
         6'd9:  e = '{12'b000110010001, 1'b1, 1'b0};
         6'd10: e = '{12'b000110001001, 1'b0, 1'b0};
         6'd11: e = '{12'b100010010001, 1'b1, 1'b0};
         6'd12: e = '{12'b010010001001, 1'b0, 1'b0};
         6'd13: e = '{12'b001001001001, 1'b0, 1'b1};
         6'd14: e = '{12'b010001001001, 1'b0, 1'b1};
         6'd15: e = '{12'b010100010001, 1'b1, 1'b0};
         6'd16: e = '{12'b010010010001, 1'b1, 1'b0};
         6'd17: e = '{12'b100100010001, 1'b1, 1'b0};
         6'd18: e = '{12'b100010001001, 1'b0, 1'b0};
         6'd19: e = '{12'b000010010101, 1'b1, 1'b0};
         6'd20: e = '{12'b000010001101, 1'b0, 1'b0};
         6'd21: e = '{12'b000010010011, 1'b1, 1'b0};
         6'd22: e = '{12'b000010001011, 1'b0, 1'b0};
         6'd23: e = '{12'b001010010101, 1'b1, 1'b0};
         6'd24: e = '{12'b001010001101, 1'b0, 1'b0};
         6'd25: e = '{12'b100010010101, 1'b1, 1'b0};
         6'd26: e = '{12'b100010110101, 1'b1, 1'b0};
         6'd27: e = '{12'b101010010101, 1'b1, 1'b0};
         6'd28: e = '{12'b010010001101, 1'b0, 1'b0};
         6'd29: e = '{12'b010010101101, 1'b0, 1'b0};
         6'd30: e = '{12'b011010101101, 1'b0, 1'b0};
         6'd31: e = '{12'b010010010101, 1'b1, 1'b0};
         6'd32: e = '{12'b010010110101, 1'b1, 1'b0};
         6'd33: e = '{12'b011010110101, 1'b1, 1'b0};
         6'd34: e = '{12'b010010010011, 1'b1, 1'b0};
         6'd35: e = '{12'b010010011001, 1'b1, 1'b0};
         6'd36: e = '{12'b010011010101, 1'b1, 1'b0};
         6'd37: e = '{12'b010110010101, 1'b1, 1'b0};
         6'd38: e = '{12'b010010100001, 1'b1, 1'b0};
         6'd39: e = '{12'b010010000101, 1'b1, 1'b0};
         6'd40: e = '{12'b010010110001, 1'b1, 1'b0};
         6'd41: e = '{12'b011010010001, 1'b1, 1'b0};
         default: e = '{12'b000000000000, 1'b0, 1'b0};
      endcase
      return e;
   endfunction

endpackage

// ----- src/ctm_datapath.sv -----
`timescale 1ns / 1ps

module ctm_datapath import ctm_pkg::*; (
   input  logic                 clock,
   input  ctm_cmd_type          cmd,
   output ctm_sts_type          sts,
   input  logic [PC_COUNT-1:0]  note_set,
   input  logic [PC_W-1:0]      bass_pitch_class,
   output logic                 found,
   output logic [PC_W-1:0]      root_pitch_class,
   output logic [PC_W-1:0]      bass_out,
   output logic [TPL_IDX_W-1:0] template_index,
   output logic                 major_family,
   output logic                 diminished
);

   function automatic logic [PC_W-1:0] popcount12(input logic [PC_COUNT-1:0] v);
      logic [PC_W-1:0] n;
      n = '0;
      for (int i = 0; i < PC_COUNT; i++) begin
         n = n + PC_W'(v[i]);
      end
      return n;
   endfunction

   logic [PC_COUNT-1:0]  set_ff, set_in;
   logic [PC_W-1:0]      bass_ff, bass_in;
   logic [PC_W-1:0]      root_ff, root_in;
   logic [TPL_IDX_W-1:0] tpl_ff, tpl_in;
   logic signed [SCORE_W-1:0] best_ff, best_in;
   logic                 found_ff, found_in;
   logic [PC_W-1:0]      win_root_ff, win_root_in;
   logic [TPL_IDX_W-1:0] win_idx_ff, win_idx_in;
   logic                 win_maj_ff, win_maj_in;
   logic                 win_dim_ff, win_dim_in;

   logic [2*PC_COUNT-1:0] dbl;
   logic [PC_COUNT-1:0]   rot;
   tpl_entry_type         tpl;
   logic [PC_W-1:0]       hit, miss, ext;
   logic signed [SCORE_W-1:0] score;
   logic                  root_on;
   logic                  tpl_last;

   always_comb begin
      dbl      = {set_ff, set_ff} >> root_ff;
      rot      = dbl[PC_COUNT-1:0];
      tpl      = tpl_rom(tpl_ff);
      hit      = popcount12(rot & tpl.mask);
      miss     = popcount12(tpl.mask & ~rot);
      ext      = popcount12(rot & ~tpl.mask);
      score    = SCORE_W'(3 * $signed({4'b0, hit}) - 2 * $signed({4'b0, miss})
                 - 2 * $signed({4'b0, ext}));
      root_on  = set_ff[root_ff];
      tpl_last = (tpl_ff == LAST_TPL);
      sts.last_step = (root_ff == LAST_ROOT) && (!root_on || tpl_last);
   end

   always_comb begin
      set_in      = set_ff;
      bass_in     = bass_ff;
      root_in     = root_ff;
      tpl_in      = tpl_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      win_root_in = win_root_ff;
      win_idx_in  = win_idx_ff;
      win_maj_in  = win_maj_ff;
      win_dim_in  = win_dim_ff;
      if (cmd.load) begin
         set_in      = note_set;
         bass_in     = bass_pitch_class;
         root_in     = '0;
         tpl_in      = '0;
         best_in     = SCORE_FLOOR;
         found_in    = 1'b0;
         win_root_in = '0;
         win_idx_in  = '0;
         win_maj_in  = 1'b1;
         win_dim_in  = 1'b0;
      end else if (cmd.step) begin
         // silent roots are skipped without trying their templates
         if (root_on && (score > best_ff)) begin
            best_in     = score;
            found_in    = 1'b1;
            win_root_in = root_ff;
            win_idx_in  = tpl_ff;
            win_maj_in  = tpl.maj;
            win_dim_in  = tpl.dim;
         end
         if (!root_on || tpl_last) begin
            tpl_in  = '0;
            root_in = root_ff + PC_W'(1);
         end else begin
            tpl_in = tpl_ff + TPL_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      bass_ff     <= bass_in;
      root_ff     <= root_in;
      tpl_ff      <= tpl_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      win_root_ff <= win_root_in;
      win_idx_ff  <= win_idx_in;
      win_maj_ff  <= win_maj_in;
      win_dim_ff  <= win_dim_in;
   end

   assign found            = found_ff;
   assign root_pitch_class = win_root_ff;
   assign bass_out         = bass_ff;
   assign template_index   = win_idx_ff;
   assign major_family     = win_maj_ff;
   assign diminished       = win_dim_ff;

endmodule

// ----- src/ctm_controller.sv -----
`timescale 1ns / 1ps

module ctm_controller import ctm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctm_cmd_type cmd,
   input  ctm_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/chord_template_matcher.sv -----
// Flow: the beat is loaded, then the scan skips each silent root and tries every
// template for each sounding root, then the result beat is offered.
// One item at a time: a new beat is refused until the result has been taken;
// the single shared scoring unit walks roots by templates.
// Reset (synchronous, active high) returns the controller to idle; no result pending.
`timescale 1ns / 1ps

module chord_template_matcher import ctm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PC_COUNT-1:0]  req_note_set,
   input  logic [PC_W-1:0]      req_bass_pitch_class,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [PC_W-1:0]      rsp_root_pitch_class,
   output logic [PC_W-1:0]      rsp_bass_out,
   output logic [TPL_IDX_W-1:0] rsp_template_index,
   output logic                 rsp_major_family,
   output logic                 rsp_diminished
);

   ctm_cmd_type cmd;
   ctm_sts_type sts;

   ctm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ctm_datapath u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .note_set         (req_note_set),
      .bass_pitch_class (req_bass_pitch_class),
      .found            (rsp_found),
      .root_pitch_class (rsp_root_pitch_class),
      .bass_out         (rsp_bass_out),
      .template_index   (rsp_template_index),
      .major_family     (rsp_major_family),
      .diminished       (rsp_diminished)
   );

endmodule

// ----- test/chord_template_matcher_tb.sv -----
`timescale 1ns / 1ps

module chord_template_matcher_tb;
   import ctm_pkg::*;

   localparam int SHAPE_COUNT = 42;

   typedef struct packed {
      logic [11:0] mask;
      logic        maj;
      logic        dim;
   } chord_shape_type;

   typedef struct packed {
      logic                 found;
      logic [PC_W-1:0]      root;
      logic [PC_W-1:0]      bass;
      logic [TPL_IDX_W-1:0] tpl;
      logic                 maj;
      logic                 dim;
   } chord_result_type;

   typedef struct {
      logic [11:0]      notes;
      chord_result_type res;
   } chord_expect_type;

   class chord_scoreboard;
      chord_expect_type   expected_q[$];
      int                 errors;
      int                 checked;
      int                 empties;
      logic [SHAPE_COUNT-1:0] won;

      function new();
         errors  = 0;
         checked = 0;
         empties = 0;
         won     = '0;
      endfunction

      function chord_shape_type shape_of(int t);
         chord_shape_type s;
         case (t)
            0:  s = '{12'h091, 1'b1, 1'b0};
            1:  s = '{12'h089, 1'b0, 1'b0};
            2:  s = '{12'h049, 1'b0, 1'b1};
            3:  s = '{12'h111, 1'b1, 1'b0};
            4:  s = '{12'h085, 1'b1, 1'b0};
            5:  s = '{12'h0A1, 1'b1, 1'b0};
            6:  s = '{12'h0A5, 1'b1, 1'b0};
            7:  s = '{12'h291, 1'b1, 1'b0};
            8:  s = '{12'h289, 1'b0, 1'b0};
            9:  s = '{12'h191, 1'b1, 1'b0};
            10: s = '{12'h189, 1'b0, 1'b0};
            11: s = '{12'h891, 1'b1, 1'b0};
            12: s = '{12'h489, 1'b0, 1'b0};
            13: s = '{12'h249, 1'b0, 1'b1};
            14: s = '{12'h449, 1'b0, 1'b1};
            15: s = '{12'h511, 1'b1, 1'b0};
            16: s = '{12'h491, 1'b1, 1'b0};
            17: s = '{12'h911, 1'b1, 1'b0};
            18: s = '{12'h889, 1'b0, 1'b0};
            19: s = '{12'h095, 1'b1, 1'b0};
            20: s = '{12'h08D, 1'b0, 1'b0};
            21: s = '{12'h093, 1'b1, 1'b0};
            22: s = '{12'h08B, 1'b0, 1'b0};
            23: s = '{12'h295, 1'b1, 1'b0};
            24: s = '{12'h28D, 1'b0, 1'b0};
            25: s = '{12'h895, 1'b1, 1'b0};
            26: s = '{12'h8B5, 1'b1, 1'b0};
            27: s = '{12'hA95, 1'b1, 1'b0};
            28: s = '{12'h48D, 1'b0, 1'b0};
            29: s = '{12'h4AD, 1'b0, 1'b0};
            30: s = '{12'h6AD, 1'b0, 1'b0};
            31: s = '{12'h495, 1'b1, 1'b0};
            32: s = '{12'h4B5, 1'b1, 1'b0};
            33: s = '{12'h6B5, 1'b1, 1'b0};
            34: s = '{12'h493, 1'b1, 1'b0};
            35: s = '{12'h499, 1'b1, 1'b0};
            36: s = '{12'h4D5, 1'b1, 1'b0};
            37: s = '{12'h595, 1'b1, 1'b0};
            38: s = '{12'h4A1, 1'b1, 1'b0};
            39: s = '{12'h485, 1'b1, 1'b0};
            40: s = '{12'h4B1, 1'b1, 1'b0};
            41: s = '{12'h691, 1'b1, 1'b0};
            default: s = '{12'h000, 1'b0, 1'b0};
         endcase
         return s;
      endfunction

      // every sounding tone tried as root; strict > keeps lowest root, then lowest shape
      function chord_result_type name_chord(logic [11:0] notes, logic [3:0] bass);
         chord_result_type r;
         chord_shape_type  s;
         logic [23:0]      twice;
         logic [11:0]      rot;
         int               best, score, hit, miss, extra, rt, t;
         r = '{found: 1'b0, root: '0, bass: bass, tpl: '0, maj: 1'b1, dim: 1'b0};
         best  = -100;
         twice = {notes, notes};
         for (rt = 0; rt < 12; rt++) begin
            if (!notes[rt]) continue;
            rot = 12'(twice >> rt);
            for (t = 0; t < TEMPLATE_COUNT && t < SHAPE_COUNT; t++) begin
               s     = shape_of(t);
               hit   = $countones(rot & s.mask);
               miss  = $countones(s.mask & ~rot);
               extra = $countones(rot & ~s.mask);
               score = 3 * hit - 2 * miss - 2 * extra;
               if (score > best) begin
                  best    = score;
                  r.found = 1'b1;
                  r.root  = PC_W'(rt);
                  r.tpl   = TPL_IDX_W'(t);
                  r.maj   = s.maj;
                  r.dim   = s.dim;
               end
            end
         end
         return r;
      endfunction

      task report(string what);
         $display("%0t ns mismatch: %s", $time, what);
         errors++;
      endtask

      function void note_input(logic [11:0] notes, logic [3:0] bass);
         chord_expect_type e;
         e.notes = notes;
         e.res   = name_chord(notes, bass);
         if (!e.res.found) empties++;
         expected_q.push_back(e);
      endfunction

      task check_field(string name, logic [11:0] notes, int got, int want);
         if (got != want)
            report($sformatf("notes %03h %s got %0d expected %0d", notes, name, got, want));
      endtask

      task check_result(chord_result_type got);
         chord_expect_type e;
         if (expected_q.size() == 0) begin
            report("result beat with no chord outstanding");
         end else begin
            e = expected_q.pop_front();
            checked++;
            check_field("found", e.notes, got.found, e.res.found);
            check_field("root", e.notes, got.root, e.res.root);
            check_field("bass", e.notes, got.bass, e.res.bass);
            check_field("template", e.notes, got.tpl, e.res.tpl);
            check_field("major", e.notes, got.maj, e.res.maj);
            check_field("diminished", e.notes, got.dim, e.res.dim);
            if (got.found && got.tpl < SHAPE_COUNT) won[got.tpl] = 1'b1;
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PC_COUNT-1:0]  req_note_set = '0;
   logic [PC_W-1:0]      req_bass_pitch_class = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   logic [PC_W-1:0]      rsp_root_pitch_class;
   logic [PC_W-1:0]      rsp_bass_out;
   logic [TPL_IDX_W-1:0] rsp_template_index;
   logic                 rsp_major_family;
   logic                 rsp_diminished;

   chord_scoreboard board = new();
   bit quiet;
   int hold_req;
   int sent;
   int blocked_cycles;

   chord_template_matcher dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_note_set         (req_note_set),
      .req_bass_pitch_class (req_bass_pitch_class),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_root_pitch_class (rsp_root_pitch_class),
      .rsp_bass_out         (rsp_bass_out),
      .rsp_template_index   (rsp_template_index),
      .rsp_major_family     (rsp_major_family),
      .rsp_diminished       (rsp_diminished)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("chord_template_matcher_tb: FAIL");
      $finish;
   end

   // mostly short, now and then long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic [11:0] voiced_chord(int t, int rt);
      chord_shape_type s;
      logic [23:0]     twice;
      s     = board.shape_of(t);
      twice = {s.mask, s.mask};
      return twice[12 - rt +: 12];
   endfunction

   task send_beat(logic [11:0] notes, logic [3:0] bass);
      req_valid            <= 1'b1;
      req_note_set         <= notes;
      req_bass_pitch_class <= bass;
      do begin
         @(posedge clock);
         if (req_stall !== 1'b0) blocked_cycles++;
      end while (req_stall !== 1'b0);
      board.note_input(notes, bass);
      sent++;
   endtask

   task rest_sender(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task play(logic [11:0] notes, logic [3:0] bass);
      send_beat(notes, bass);
      rest_sender(gap_len());
   endtask

   task random_chord();
      logic [11:0] notes;
      logic [3:0]  bass;
      int          pick, k;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         notes = voiced_chord($urandom_range(0, SHAPE_COUNT - 1), $urandom_range(0, 11));
         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 11);
            notes[k] = ~notes[k];
         end
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, 11);
            notes[k] = ~notes[k];
         end
      end else if (pick < 85) begin
         notes = 12'($urandom);
      end else if (pick < 95) begin
         notes = '0;
         k = $urandom_range(0, 11);
         notes[k] = 1'b1;
         k = $urandom_range(0, 11);
         notes[k] = 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
         notes = 12'h000;
      end else begin
         notes = 12'hFFF ^ (12'h001 << $urandom_range(0, 11));
      end
      if ($urandom_range(0, 9) == 0) bass = 4'($urandom_range(12, 15));
      else bass = 4'($urandom_range(0, 11));
      play(notes, bass);
   endtask

   // result side: checks accepted beats and throttles with rsp_stall
   initial begin : result_side
      int stall_left;
      chord_result_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got = '{rsp_found, rsp_root_pitch_class, rsp_bass_out, rsp_template_index,
                    rsp_major_family, rsp_diminished};
            board.check_result(got);
         end
         if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
            stall_left = 1 + gap_len();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int i;
      quiet          = 1'b0;
      hold_req       = 0;
      sent           = 0;
      blocked_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge cases: empty, full, single notes, wraparound, symmetric shapes, high bass
      play(12'h000, 4'd0);
      play(12'h000, 4'd15);
      play(12'hFFF, 4'd11);
      play(12'h001, 4'd0);
      play(12'h800, 4'd11);
      play(12'h091, 4'd0);
      play(12'h089, 4'd3);
      play(12'h211, 4'd9);
      play(12'h824, 4'd11);
      play(12'h111, 4'd4);
      play(12'h848, 4'd11);
      play(12'h8A4, 4'd7);
      play(12'h891, 4'd12);
      play(12'h0A1, 4'd13);
      play(12'h249, 4'd14);
      play(12'h555, 4'd15);
      play(12'hAAA, 4'd5);
      play(12'hA95, 4'd0);
      play(12'h6AD, 4'd2);
      play(12'h041, 4'd6);
      play(12'h007, 4'd1);
      play(12'hFFE, 4'd10);
      play(12'h7FF, 4'd3);
      play(12'hC03, 4'd8);

      for (i = 0; i < 1146; i++) begin
         quiet = (i >= 300 && i < 400);
         if (i == 600) hold_req = 4000;
         if (i >= 600 && i < 620) begin
            // keep offering back to back while the result side is held off
            send_beat(voiced_chord($urandom_range(0, SHAPE_COUNT - 1), $urandom_range(0, 11)),
                      4'($urandom_range(0, 11)));
         end else begin
            random_chord();
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("%0d chords sent, %0d results checked, %0d empty sets, %0d cycles input blocked",
               sent, board.checked, board.empties, blocked_cycles);
      $display("%0d of %0d templates seen as winners", $countones(board.won), SHAPE_COUNT);
      if (board.pending() != 0)
         board.report($sformatf("%0d expected results never arrived", board.pending()));
      if (board.errors == 0) begin
         $display("chord_template_matcher_tb: PASS");
      end else begin
         $display("chord_template_matcher_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- chord_template_matcher.f -----
src/ctm_pkg.sv
src/ctm_datapath.sv
src/ctm_controller.sv
src/chord_template_matcher.sv
test/chord_template_matcher_tb.sv
